// ----- hdl/fp8dq_pkg.sv -----
`timescale 1ns / 1ps

package fp8dq_pkg;

	localparam int unsigned LANES = 4;

	localparam logic [15:0] BF16_NAN = 16'h7FC0;
	localparam logic [14:0] BF16_INF_MAG = 15'h7F80;
	localparam logic [3:0] E4M3_EXP_MAX = 4'hF;
	localparam logic [2:0] E4M3_MANT_MAX = 3'h7;
	localparam logic [7:0] F32_EXP_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0]  code_zero;
		logic [7:0]  code_one;
		logic [7:0]  code_two;
		logic [7:0]  code_three;
		logic [31:0] group_scale;
	} code_item_t;

	typedef struct packed {
		logic [15:0] value_zero;
		logic [15:0] value_one;
		logic [15:0] value_two;
		logic [15:0] value_three;
	} value_item_t;

	typedef struct packed {
		logic        special;
		logic [15:0] special_value;
		logic [31:0] product;
	} lane_result_t;

endpackage

// ----- hdl/fp8dq_lane.sv -----
`timescale 1ns / 1ps

module fp8dq_lane (
	input  logic                      clk,
	input  logic                      en_s1,
	input  logic                      en_s2,
	input  logic [7:0]                code,
	input  logic [31:0]               scale,
	output fp8dq_pkg::lane_result_t   result
);

	logic        sign;
	logic [3:0]  ce;
	logic [2:0]  cm;
	logic [7:0]  se;
	logic [22:0] sf;
	logic [3:0]  csig;
	logic [23:0] ssig;
	logic signed [10:0] cex;
	logic signed [10:0] sex;
	logic        special;
	logic [15:0] special_value;

	logic [27:0] prod_s1;
	logic signed [10:0] ex_s1;
	logic        sign_s1;
	logic        special_s1;
	logic [15:0] special_value_s1;

	always_comb begin
		sign = code[7] ^ scale[31];
		ce = code[6:3];
		cm = code[2:0];
		se = scale[30:23];
		sf = scale[22:0];
		if (ce == 4'd0) begin
			csig = {1'b0, cm};
			cex = -11'sd9;
		end else begin
			csig = {1'b1, cm};
			cex = $signed({7'd0, ce}) - 11'sd10;
		end
		if (se == 8'd0) begin
			ssig = {1'b0, sf};
			sex = -11'sd149;
		end else begin
			ssig = {1'b1, sf};
			sex = $signed({3'd0, se}) - 11'sd150;
		end
		special = 1'b0;
		special_value = fp8dq_pkg::BF16_NAN;
		if (ce == fp8dq_pkg::E4M3_EXP_MAX && cm == fp8dq_pkg::E4M3_MANT_MAX) begin
			special = 1'b1;
		end else if (se == fp8dq_pkg::F32_EXP_MAX) begin
			special = 1'b1;
			if (sf == 23'd0 && !(ce == 4'd0 && cm == 3'd0)) begin
				special_value = {sign, fp8dq_pkg::BF16_INF_MAG};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= 28'(csig * ssig);
			ex_s1 <= cex + sex;
			sign_s1 <= sign;
			special_s1 <= special;
			special_value_s1 <= special_value;
		end
	end

	logic [4:0]  p;
	logic signed [10:0] e_norm;
	logic signed [10:0] q;
	logic signed [10:0] sh;
	logic signed [10:0] nsh;
	logic signed [10:0] biased;
	logic [50:0] wide;
	logic [3:0]  shr;
	logic [27:0] low;
	logic [27:0] half;
	logic [24:0] r;
	logic [31:0] f32;

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (prod_s1[i]) begin
				p = 5'(i);
			end
		end
		e_norm = $signed({6'd0, p}) + ex_s1 - 11'sd23;
		q = (e_norm < -11'sd149) ? -11'sd149 : e_norm;
		sh = q - ex_s1;
		nsh = -sh;
		wide = {23'd0, prod_s1} << nsh[4:0];
		shr = sh[3:0];
		low = 28'd0;
		half = 28'd0;
		if (sh <= 11'sd0) begin
			r = wide[24:0];
		end else begin
			low = prod_s1 & ((28'd1 << shr) - 28'd1);
			half = 28'd1 << (shr - 4'd1);
			r = 25'(prod_s1 >> shr);
			if (low > half || (low == half && r[0])) begin
				r = r + 25'd1;
			end
		end
		if (r[24]) begin
			r = 25'h0800000;
			q = q + 11'sd1;
		end
		biased = q + 11'sd150;
		if (r[23]) begin
			if (biased >= 11'sd255) begin
				f32 = {sign_s1, 31'h7F800000};
			end else begin
				f32 = {sign_s1, biased[7:0], r[22:0]};
			end
		end else begin
			f32 = {sign_s1, 8'd0, r[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			result.product <= f32;
			result.special <= special_s1;
			result.special_value <= special_value_s1;
		end
	end

endmodule

// ----- hdl/fp8_block_scaled_dequant_bf16.sv -----
`timescale 1ns / 1ps
// fp8 e4m3 block-scaled dequantizer to bf16
// input channel codes: four e4m3 codes and the fp32 group scale per item,
// taken when code_valid is high and code_stall is low
// output channel values: four bf16 patterns per item, delivered when
// value_valid is high and value_stall is low
// one item in, one item out, in order
// an accepted item moves through the lane multiply register and the lane
// normalize register into the output register, where value_valid rises
// throughput: one item per cycle while the receiver does not stall, set by
// the four lanes each holding one fp32 multiply stage and one normalize and
// round stage, then a bf16 round and output register that merges the lanes
// every stage moves on its own when the one after it is free, so items
// keep being taken while a finished item waits in the output register
// code_stall rises only when all three stages hold items and the receiver
// stalls
// reset clears all stage valid flags; no item is in flight afterwards

module fp8_block_scaled_dequant_bf16 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      code_valid,
	output logic                      code_stall,
	input  fp8dq_pkg::code_item_t     codes,
	output logic                      value_valid,
	input  logic                      value_stall,
	output fp8dq_pkg::value_item_t    values
);

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;
	logic take;

	assign ready_s3 = !valid_s3 || !value_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign code_stall = !ready_s1;
	assign take = code_valid && ready_s1;
	assign value_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= code_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	logic [7:0] lane_code [fp8dq_pkg::LANES];
	fp8dq_pkg::lane_result_t lane_res [fp8dq_pkg::LANES];
	logic [15:0] lane_bf16 [fp8dq_pkg::LANES];

	assign lane_code[0] = codes.code_zero;
	assign lane_code[1] = codes.code_one;
	assign lane_code[2] = codes.code_two;
	assign lane_code[3] = codes.code_three;

	for (genvar g = 0; g < fp8dq_pkg::LANES; g++) begin : g_lane
		logic [32:0] t;
		fp8dq_lane u_lane (
			.clk    (clk),
			.en_s1  (take),
			.en_s2  (valid_s1 && ready_s2),
			.code   (lane_code[g]),
			.scale  (codes.group_scale),
			.result (lane_res[g])
		);
		assign t = {1'b0, lane_res[g].product} + 33'h7FFF
			+ {32'd0, lane_res[g].product[16]};
		assign lane_bf16[g] = lane_res[g].special ? lane_res[g].special_value : t[31:16];
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			values.value_zero <= lane_bf16[0];
			values.value_one <= lane_bf16[1];
			values.value_two <= lane_bf16[2];
			values.value_three <= lane_bf16[3];
		end
	end

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		code_stall |-> (valid_s1 && valid_s2 && valid_s3 && value_stall))
		else $error("input stalled with a free stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> valid_s1)
		else $error("stage one item lost");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_s3) |=> valid_s2)
		else $error("stage two item lost");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	logic clk;
	logic arst_n;
	logic code_valid;
	logic code_stall;
	fp8dq_pkg::code_item_t codes;
	logic value_valid;
	logic value_stall;
	fp8dq_pkg::value_item_t values;

	fp8dq_pkg::code_item_t pending_codes[$];
	fp8dq_pkg::value_item_t expected_values[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_cycles;
	int unsigned mismatches;
	int unsigned cycle_count;

	fp8_block_scaled_dequant_bf16 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.codes(codes),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.values(values)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [31:0] round_f32(logic sign, logic [63:0] sig, int ex);
		int p;
		int q;
		int shift;
		logic [63:0] r;
		logic [63:0] half;
		logic [63:0] low;
		int biased;
		if (sig == 0) return {sign, 31'd0};
		p = 0;
		for (int b = 63; b >= 0; b--) begin
			if (sig[b]) begin
				p = b;
				break;
			end
		end
		q = p + ex - 23;
		if (q < -149) q = -149;
		shift = q - ex;
		if (shift <= 0) begin
			r = sig << (-shift);
		end else if (shift >= 40) begin
			r = 0;
		end else begin
			half = 64'd1 << (shift - 1);
			low = sig & ((64'd1 << shift) - 1);
			r = sig >> shift;
			if (low > half || (low == half && r[0])) r = r + 1;
		end
		if (r == (64'd1 << 24)) begin
			r = 64'd1 << 23;
			q++;
		end
		if (r >= (64'd1 << 23)) begin
			biased = q + 150;
			if (biased >= 255) return {sign, 31'h7F800000};
			return {sign, biased[7:0], r[22:0]};
		end
		return {sign, r[30:0]};
	endfunction

	function automatic logic [15:0] scaled_bf16(logic [7:0] code, logic [31:0] scale);
		logic sign;
		logic [63:0] csig;
		logic [63:0] ssig;
		int cex;
		int sex;
		logic [31:0] f;
		logic [32:0] t;
		sign = code[7] ^ scale[31];
		if (code[6:3] == fp8dq_pkg::E4M3_EXP_MAX && code[2:0] == fp8dq_pkg::E4M3_MANT_MAX)
			return fp8dq_pkg::BF16_NAN;
		if (scale[30:23] == fp8dq_pkg::F32_EXP_MAX) begin
			if (scale[22:0] != 0) return fp8dq_pkg::BF16_NAN;
			if (code[6:0] == 0) return fp8dq_pkg::BF16_NAN;
			return {sign, fp8dq_pkg::BF16_INF_MAG};
		end
		if (code[6:3] == 0) begin
			csig = code[2:0];
			cex = -9;
		end else begin
			csig = 8 + code[2:0];
			cex = int'(code[6:3]) - 10;
		end
		if (scale[30:23] == 0) begin
			ssig = scale[22:0];
			sex = -149;
		end else begin
			ssig = {1'b1, scale[22:0]};
			sex = int'(scale[30:23]) - 150;
		end
		f = round_f32(sign, csig * ssig, cex + sex);
		t = {1'b0, f} + 33'h7FFF + f[16];
		return t[31:16];
	endfunction

	function automatic fp8dq_pkg::value_item_t dequant_item(fp8dq_pkg::code_item_t c);
		fp8dq_pkg::value_item_t v;
		v.value_zero = scaled_bf16(c.code_zero, c.group_scale);
		v.value_one = scaled_bf16(c.code_one, c.group_scale);
		v.value_two = scaled_bf16(c.code_two, c.group_scale);
		v.value_three = scaled_bf16(c.code_three, c.group_scale);
		return v;
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return {1'($urandom), 8'd0, 23'($urandom)};
			2: return {1'($urandom), fp8dq_pkg::F32_EXP_MAX,
				($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom)};
			3: return {1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)};
			4: return {1'($urandom), 8'($urandom_range(1, 20)), 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
		endcase
	endfunction

	task automatic queue_item(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
			logic [31:0] s);
		fp8dq_pkg::code_item_t it;
		it.code_zero = a;
		it.code_one = b;
		it.code_two = c;
		it.code_three = d;
		it.group_scale = s;
		pending_codes.push_back(it);
	endtask

	task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) queue_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			pick_scale());
		wait (pending_codes.size() == 0);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid <= 1'b0;
			codes <= '0;
		end else if (!code_valid || !code_stall) begin
			if (code_valid) expected_values.push_back(dequant_item(codes));
			if (pending_codes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				code_valid <= 1'b1;
				codes <= pending_codes.pop_front();
			end else begin
				code_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_stall <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			value_stall <= 1'b1;
		end else begin
			value_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		fp8dq_pkg::value_item_t exp_v;
		cycle_count <= cycle_count + 1;
		if (arst_n && value_valid && !value_stall) begin
			if (expected_values.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected item %h", values);
			end else begin
				exp_v = expected_values.pop_front();
				if (values.value_zero !== exp_v.value_zero || values.value_one !== exp_v.value_one
						|| values.value_two !== exp_v.value_two
						|| values.value_three !== exp_v.value_three) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch expected %h actual %h", exp_v, values);
				end
			end
		end
		if (cycle_count > 400000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		mismatches = 0;
		cycle_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// extremes, nan codes, zero codes, subnormal codes
		queue_item(8'h00, 8'h80, 8'h7F, 8'hFF, 32'h3F800000);
		queue_item(8'h7E, 8'hFE, 8'h01, 8'h81, 32'h3F800000);
		queue_item(8'h07, 8'h08, 8'h77, 8'hF7, 32'hBF800000);
		queue_item(8'h00, 8'h01, 8'h7E, 8'h80, 32'h7F800000);
		queue_item(8'h00, 8'h01, 8'h7E, 8'h80, 32'hFF800000);
		queue_item(8'h00, 8'h01, 8'h7E, 8'h80, 32'h7FC00000);
		queue_item(8'h00, 8'h01, 8'h7E, 8'h80, 32'hFF800001);
		queue_item(8'h7E, 8'hFE, 8'h70, 8'h6F, 32'h7F7FFFFF);
		queue_item(8'h01, 8'h81, 8'h08, 8'h7E, 32'h00000001);
		queue_item(8'h01, 8'h40, 8'h7E, 8'h38, 32'h007FFFFF);
		queue_item(8'h00, 8'h80, 8'h38, 8'hB8, 32'h00000000);
		queue_item(8'h00, 8'h80, 8'h38, 8'hB8, 32'h80000000);
		queue_item(8'h39, 8'h3A, 8'h3B, 8'h3C, 32'h3F80FFFF);
		queue_item(8'h7E, 8'h7D, 8'h7C, 8'h7B, 32'h7E000000);
		queue_item(8'h01, 8'h02, 8'h03, 8'h05, 32'h01000000);
		queue_item(8'h55, 8'hAA, 8'h33, 8'hCC, 32'hFFFFFFFF);
		queue_item(8'h38, 8'h38, 8'h38, 8'h38, 32'h3F808000);
		queue_item(8'h38, 8'h39, 8'h38, 8'h39, 32'h3F818000);
		wait (pending_codes.size() == 0);
		run_phase(150, 0, 0);
		run_phase(150, 52, 0);
		run_phase(150, 0, 52);
		run_phase(150, 37, 37);
		// long receiver hold while items keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_cycles <= 60;
		run_phase(130, 0, 0);
		@(posedge clk);
		while (code_valid || expected_values.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_values.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
